@@ rtl/topk_overlap_recall_histogram_defines.svh @@
// Assertion macros shared by the RTL of the recall histogram block.
// Each macro expects signals named clock and reset in the calling scope.
`ifndef TOPK_OVERLAP_RECALL_HISTOGRAM_DEFINES_SVH
`define TOPK_OVERLAP_RECALL_HISTOGRAM_DEFINES_SVH

// Check a consequent in the same cycle as its antecedent.
`define TKOR_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define TKOR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/tkor_pkg.sv @@
package tkor_pkg;

   // Field widths fixed by the interface
   localparam int ID_W   = 12;
   localparam int BIN_W  = 32;
   localparam int BIDX_W = 6;
   localparam int CFG_W  = 7;

   // Default depth of the ground-truth list and the histogram
   localparam int K_MAX_DEF = 64;

   // Ids at or beyond this count are out of the database range
   localparam logic [31:0] DB_SIZE = 32'd4096;

   // Value of valid_k after reset
   localparam logic [CFG_W-1:0] VALID_K_RST = 7'd64;

   typedef enum logic [1:0] {
      CMD_TRUTH,
      CMD_RETR,
      CMD_READ,
      CMD_CLEAR
   } tkor_cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCAN,
      ST_BIN_READ,
      ST_BIN_UPD,
      ST_FINISH
   } tkor_state_type;

   // Control word for the histogram memory
   typedef struct packed {
      logic rd_en;
      logic wr_en;
      logic clear;
   } tkor_bin_ctl_type;

endpackage

@@ rtl/tkor_truth_mem.sv @@
module tkor_truth_mem #(
   parameter int DEPTH = tkor_pkg::K_MAX_DEF,
   parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [IDX_W-1:0]          wr_addr,
   input  logic [tkor_pkg::ID_W-1:0] wr_data,
   input  logic [IDX_W-1:0]          rd_addr,
   output logic [tkor_pkg::ID_W-1:0] rd_data
);
   import tkor_pkg::*;

   logic [ID_W-1:0] mem_ff [DEPTH];
   logic [ID_W-1:0] rd_data_ff;

   // Write the ground-truth id at its rank
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Register the read word
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/tkor_bin_mem.sv @@
module tkor_bin_mem #(
   parameter int DEPTH = tkor_pkg::K_MAX_DEF,
   parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                         clock,
   input  logic                         reset,
   input  tkor_pkg::tkor_bin_ctl_type   ctl,
   input  logic [IDX_W-1:0]             rd_addr,
   input  logic [IDX_W-1:0]             wr_addr,
   input  logic [tkor_pkg::BIN_W-1:0]   wr_data,
   output logic [tkor_pkg::BIN_W-1:0]   rd_data
);
   import tkor_pkg::*;

   logic [BIN_W-1:0] mem_ff [DEPTH];
   logic [DEPTH-1:0] vld_ff;
   logic [DEPTH-1:0] vld_in;
   logic [BIN_W-1:0] rd_word_ff;
   logic             rd_vld_ff;
   logic             rd_vld_in;

   // Track written bins; clear drops them all at once
   always_comb begin
      vld_in    = vld_ff;
      rd_vld_in = rd_vld_ff;
      if (ctl.clear) begin
         vld_in = '0;
      end else if (ctl.wr_en) begin
         vld_in[wr_addr] = 1'b1;
      end
      if (ctl.rd_en) begin
         rd_vld_in = vld_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         vld_ff    <= vld_in;
         rd_vld_ff <= rd_vld_in;
      end
   end

   // Memory array: one write and one registered read
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_word_ff <= mem_ff[rd_addr];
      end
   end

   // A bin never written since reset or clear reads as zero
   assign rd_data = rd_vld_ff ? rd_word_ff : '0;

endmodule

@@ rtl/topk_overlap_recall_histogram.sv @@
// Flow: ground-truth id, clear and rejected items pass through EXEC and FINISH after acceptance;
// bin read adds BIN_READ; a retrieved id spends a SCAN step on each rank scanned back from the
// newest ground-truth entry to the match (up to the list length), then BIN_UPD for a bin update.
// Throughput: one item at a time, next item accepted the cycle after the result is registered;
// the scan over the ground-truth memory, one entry per cycle, sets the retrieved-id time.
// Reset: synchronous; clears ranks, bin marks and all bins at once, valid_k returns to 64.
`include "topk_overlap_recall_histogram_defines.svh"

module topk_overlap_recall_histogram #(
   parameter int K_MAX = tkor_pkg::K_MAX_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [1:0]                  req_cmd,
   input  logic [tkor_pkg::ID_W-1:0]   req_item_id,
   input  logic                        req_new_query,
   input  logic [tkor_pkg::BIDX_W-1:0] req_bin_index,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_hit,
   output logic [tkor_pkg::BIDX_W-1:0] rsp_bin_hit,
   output logic [tkor_pkg::BIN_W-1:0]  rsp_bin_count,
   output logic                        rsp_status,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [tkor_pkg::CFG_W-1:0]  csr_wdata
);
   import tkor_pkg::*;

   localparam int RANK_W = $clog2(K_MAX + 1);
   localparam int IDX_W  = (K_MAX > 1) ? $clog2(K_MAX) : 1;
   localparam logic [CFG_W-1:0] K_MAX_W = CFG_W'(K_MAX);

   // State machine
   tkor_state_type state_ff, state_in;

   // Captured word
   tkor_cmd_type      cmd_ff, cmd_in;
   logic [ID_W-1:0]   id_ff, id_in;
   logic              nq_ff, nq_in;
   logic [BIDX_W-1:0] bidx_ff, bidx_in;

   // Query state
   logic [CFG_W-1:0]  valid_k_ff, valid_k_in;
   logic [RANK_W-1:0] truth_rank_ff, truth_rank_in;
   logic [RANK_W-1:0] retr_rank_ff, retr_rank_in;
   logic [K_MAX-1:0]  marked_ff, marked_in;

   // Scan and bin update
   logic [RANK_W-1:0] j_ff, j_in;
   logic [IDX_W-1:0]  scan_addr_ff, scan_addr_in;
   logic [IDX_W-1:0]  bin_addr_ff, bin_addr_in;

   // Pending result
   logic              res_hit_ff, res_hit_in;
   logic [BIDX_W-1:0] res_bin_hit_ff, res_bin_hit_in;
   logic [BIN_W-1:0]  res_count_ff, res_count_in;
   logic              res_status_ff, res_status_in;

   // Output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_hit_ff, rsp_hit_in;
   logic [BIDX_W-1:0] rsp_bin_hit_ff, rsp_bin_hit_in;
   logic [BIN_W-1:0]  rsp_count_ff, rsp_count_in;
   logic              rsp_status_ff, rsp_status_in;

   // Decode and datapath signals
   logic              req_accept;
   logic              out_free;
   logic [CFG_W-1:0]  k_eff;
   logic              id_ok;
   logic [RANK_W-1:0] truth_base;
   logic              truth_ok;
   logic              retr_ok;
   logic              bidx_ok;
   logic [RANK_W-1:0] rank_m1;
   logic [RANK_W-1:0] pos_ext;
   logic [RANK_W-1:0] bin_b;
   logic [IDX_W-1:0]  bin_b_idx;
   logic              scan_match;

   // Memory ports
   logic              truth_we;
   logic [IDX_W-1:0]  truth_waddr;
   logic [IDX_W-1:0]  truth_raddr;
   logic [ID_W-1:0]   truth_rdata;
   tkor_bin_ctl_type  bin_ctl;
   logic [IDX_W-1:0]  bin_raddr;
   logic [BIN_W-1:0]  bin_wdata;
   logic [BIN_W-1:0]  bin_rdata;

   assign req_accept = req_valid && req_ready;
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign csr_ready  = 1'b1;

   // Clamp valid_k to 1..K_MAX
   always_comb begin
      if (valid_k_ff == '0) begin
         k_eff = CFG_W'(1);
      end else if (valid_k_ff > K_MAX_W) begin
         k_eff = K_MAX_W;
      end else begin
         k_eff = valid_k_ff;
      end
   end

   // Range checks on the captured word
   assign id_ok      = (32'(id_ff) < DB_SIZE);
   assign truth_base = nq_ff ? '0 : truth_rank_ff;
   assign truth_ok   = id_ok && (CFG_W'(truth_base) < k_eff);
   assign retr_ok    = id_ok && (CFG_W'(retr_rank_ff) < k_eff);
   assign bidx_ok    = (CFG_W'(bidx_ff) < K_MAX_W);
   assign rank_m1    = truth_rank_ff - RANK_W'(1);

   // Bin of a match: the later of the two ranks
   assign pos_ext    = RANK_W'(scan_addr_ff);
   assign bin_b      = (j_ff >= pos_ext) ? j_ff : pos_ext;
   assign bin_b_idx  = bin_b[IDX_W-1:0];
   assign scan_match = (truth_rdata == id_ff);

   // Saturating increment of the bin being updated
   assign bin_wdata  = (bin_rdata == '1) ? bin_rdata : bin_rdata + BIN_W'(1);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            unique case (cmd_ff)
               CMD_RETR: begin
                  state_in = (retr_ok && truth_rank_ff != '0) ? ST_SCAN : ST_FINISH;
               end
               CMD_READ: begin
                  state_in = bidx_ok ? ST_BIN_READ : ST_FINISH;
               end
               CMD_TRUTH, CMD_CLEAR: begin
                  state_in = ST_FINISH;
               end
            endcase
         end
         ST_SCAN: begin
            if (scan_match) begin
               state_in = marked_ff[bin_b_idx] ? ST_FINISH : ST_BIN_UPD;
            end else if (scan_addr_ff == '0) begin
               state_in = ST_FINISH;
            end
         end
         ST_BIN_READ: begin
            state_in = ST_FINISH;
         end
         ST_BIN_UPD: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State machine outputs: handshake and memory controls
   always_comb begin
      req_ready     = 1'b0;
      truth_we      = 1'b0;
      truth_waddr   = truth_base[IDX_W-1:0];
      truth_raddr   = '0;
      bin_ctl       = '0;
      bin_raddr     = bin_b_idx;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
         end
         ST_EXEC: begin
            truth_raddr   = rank_m1[IDX_W-1:0];
            truth_we      = (cmd_ff == CMD_TRUTH) && truth_ok;
            bin_ctl.rd_en = (cmd_ff == CMD_READ) && bidx_ok;
            bin_ctl.clear = (cmd_ff == CMD_CLEAR);
            bin_raddr     = bidx_ff[IDX_W-1:0];
         end
         ST_SCAN: begin
            truth_raddr   = scan_addr_ff - IDX_W'(1);
            bin_ctl.rd_en = scan_match && !marked_ff[bin_b_idx];
         end
         ST_BIN_UPD: begin
            bin_ctl.wr_en = 1'b1;
         end
         ST_BIN_READ, ST_FINISH: begin
            req_ready = 1'b0;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // Datapath next values
   always_comb begin
      cmd_in         = cmd_ff;
      id_in          = id_ff;
      nq_in          = nq_ff;
      bidx_in        = bidx_ff;
      valid_k_in     = valid_k_ff;
      truth_rank_in  = truth_rank_ff;
      retr_rank_in   = retr_rank_ff;
      marked_in      = marked_ff;
      j_in           = j_ff;
      scan_addr_in   = scan_addr_ff;
      bin_addr_in    = bin_addr_ff;
      res_hit_in     = res_hit_ff;
      res_bin_hit_in = res_bin_hit_ff;
      res_count_in   = res_count_ff;
      res_status_in  = res_status_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_hit_in     = rsp_hit_ff;
      rsp_bin_hit_in = rsp_bin_hit_ff;
      rsp_count_in   = rsp_count_ff;
      rsp_status_in  = rsp_status_ff;

      // Take a configuration word
      if (csr_valid && csr_ready) begin
         valid_k_in = csr_wdata;
      end

      // Drop the result once taken
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               cmd_in  = tkor_cmd_type'(req_cmd);
               id_in   = req_item_id;
               nq_in   = req_new_query;
               bidx_in = req_bin_index;
            end
         end
         ST_EXEC: begin
            res_hit_in     = 1'b0;
            res_bin_hit_in = '0;
            res_count_in   = '0;
            res_status_in  = 1'b0;
            unique case (cmd_ff)
               CMD_TRUTH: begin
                  if (nq_ff) begin
                     retr_rank_in = '0;
                     marked_in    = '0;
                  end
                  truth_rank_in = truth_ok ? truth_base + RANK_W'(1) : truth_base;
                  res_status_in = !truth_ok;
               end
               CMD_RETR: begin
                  res_status_in = !retr_ok;
                  j_in          = retr_rank_ff;
                  scan_addr_in  = rank_m1[IDX_W-1:0];
                  if (retr_ok) begin
                     retr_rank_in = retr_rank_ff + RANK_W'(1);
                  end
               end
               CMD_READ: begin
                  res_status_in = !bidx_ok;
               end
               CMD_CLEAR: begin
                  marked_in = '0;
               end
            endcase
         end
         ST_SCAN: begin
            if (scan_match) begin
               res_hit_in     = 1'b1;
               res_bin_hit_in = BIDX_W'(bin_b);
               bin_addr_in    = bin_b_idx;
            end else begin
               scan_addr_in   = scan_addr_ff - IDX_W'(1);
            end
         end
         ST_BIN_READ: begin
            res_count_in = bin_rdata;
         end
         ST_BIN_UPD: begin
            marked_in[bin_addr_ff] = 1'b1;
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_hit_in     = res_hit_ff;
               rsp_bin_hit_in = res_bin_hit_ff;
               rsp_count_in   = res_count_ff;
               rsp_status_in  = res_status_ff;
            end
         end
         default: begin
            rsp_valid_in = rsp_valid_ff;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         valid_k_ff    <= VALID_K_RST;
         truth_rank_ff <= '0;
         retr_rank_ff  <= '0;
         marked_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         valid_k_ff    <= valid_k_in;
         truth_rank_ff <= truth_rank_in;
         retr_rank_ff  <= retr_rank_in;
         marked_ff     <= marked_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cmd_ff         <= cmd_in;
      id_ff          <= id_in;
      nq_ff          <= nq_in;
      bidx_ff        <= bidx_in;
      j_ff           <= j_in;
      scan_addr_ff   <= scan_addr_in;
      bin_addr_ff    <= bin_addr_in;
      res_hit_ff     <= res_hit_in;
      res_bin_hit_ff <= res_bin_hit_in;
      res_count_ff   <= res_count_in;
      res_status_ff  <= res_status_in;
      rsp_hit_ff     <= rsp_hit_in;
      rsp_bin_hit_ff <= rsp_bin_hit_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_status_ff  <= rsp_status_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_hit       = rsp_hit_ff;
   assign rsp_bin_hit   = rsp_bin_hit_ff;
   assign rsp_bin_count = rsp_count_ff;
   assign rsp_status    = rsp_status_ff;

   // Ground-truth id memory
   tkor_truth_mem #(
      .DEPTH (K_MAX)
   ) u_truth_mem (
      .clock   (clock),
      .wr_en   (truth_we),
      .wr_addr (truth_waddr),
      .wr_data (id_ff),
      .rd_addr (truth_raddr),
      .rd_data (truth_rdata)
   );

   // Histogram memory
   tkor_bin_mem #(
      .DEPTH (K_MAX)
   ) u_bin_mem (
      .clock   (clock),
      .reset   (reset),
      .ctl     (bin_ctl),
      .rd_addr (bin_raddr),
      .wr_addr (bin_addr_ff),
      .wr_data (bin_wdata),
      .rd_data (bin_rdata)
   );

   `TKOR_ASSERT_NOW(a_scan_below_rank, state_ff == ST_SCAN, RANK_W'(scan_addr_ff) < truth_rank_ff, "scan address beyond ground-truth list")
   `TKOR_ASSERT_NOW(a_rank_bound, 1'b1, (CFG_W'(truth_rank_ff) <= K_MAX_W) && (CFG_W'(retr_rank_ff) <= K_MAX_W), "rank counter beyond list depth")
   `TKOR_ASSERT_NOW(a_update_unmarked, state_ff == ST_BIN_UPD, !marked_ff[bin_addr_ff], "bin counted twice in one query")
   `TKOR_ASSERT_NEXT(a_accept_exec, req_valid && req_ready, state_ff == ST_EXEC, "accepted word not executed")

endmodule
